// ===== design/phct_pkg.sv =====
// Shared types and constants for the page hotness counter table.
`default_nettype none

package phct_pkg;

  localparam int PAGES   = 1024;
  localparam int CPUS    = 8;
  localparam int PAGE_AW = $clog2(PAGES);

  localparam logic [7:0]  COUNT_MAX       = 8'd255;
  localparam logic [7:0]  AGE_MAX         = 8'd255;
  localparam logic [10:0] TOTAL_MAX       = 11'd2047;
  localparam logic [10:0] TOTAL_BOUND     = 11'd2040;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd8;

  typedef enum logic [1:0] {
    CMD_ACCESS    = 2'd0,
    CMD_AGE_TICK  = 2'd1,
    CMD_CLR_COUNT = 2'd2,
    CMD_CLR_AGE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  // One page record as held in the table memory.
  typedef struct packed {
    logic [CPUS-1:0][7:0] counts;
    logic [10:0]          total;
    logic [7:0]           age;
  } rec_t;

  // Command as seen by the update logic.
  typedef struct packed {
    cmd_t       op;
    logic [2:0] cpu_id;
    logic       cpu_ok;
  } upd_ctl_t;

endpackage

`default_nettype wire

// ===== design/phct_update.sv =====
// Modify step of the read-modify-write: applies one command to a page record.
`default_nettype none

module phct_update
  import phct_pkg::*;
(
  input  upd_ctl_t    ctl,
  input  logic [7:0]  cold_threshold,
  input  rec_t        rec_in,
  output rec_t        rec_out,
  output logic [7:0]  cpu_count
);

  logic [7:0]  cur;
  logic [7:0]  age_inc;
  logic [10:0] total_dec;
  logic        bump;

  always_comb begin
    cur = '0;
    for (int i = 0; i < CPUS; i++) begin
      if (ctl.cpu_ok && ctl.cpu_id == 3'(i)) begin
        cur = rec_in.counts[i];
      end
    end
  end

  assign bump      = ctl.cpu_ok && (cur != COUNT_MAX);
  assign age_inc   = (rec_in.age != AGE_MAX) ? rec_in.age + 8'd1 : rec_in.age;
  assign total_dec = (rec_in.total != 11'd0) ? rec_in.total - 11'd1 : 11'd0;

  always_comb begin
    rec_out = rec_in;
    unique case (ctl.op)
      CMD_ACCESS: begin
        if (ctl.cpu_ok) begin
          rec_out.age = '0;
          if (bump) begin
            for (int i = 0; i < CPUS; i++) begin
              if (ctl.cpu_id == 3'(i)) begin
                rec_out.counts[i] = cur + 8'd1;
              end
            end
            if (rec_in.total != TOTAL_MAX) begin
              rec_out.total = rec_in.total + 11'd1;
            end
          end
        end
      end
      CMD_AGE_TICK: begin
        rec_out.age = age_inc;
        if (age_inc > cold_threshold) begin
          rec_out.total = total_dec;
          // page went cold: drop the whole record
          if (total_dec == 11'd0) begin
            rec_out.age    = '0;
            rec_out.counts = '0;
          end
        end
      end
      CMD_CLR_COUNT: begin
        rec_out.total  = '0;
        rec_out.counts = '0;
      end
      CMD_CLR_AGE: begin
        rec_out.age = '0;
      end
      default: begin
        rec_out = rec_in;
      end
    endcase
  end

  always_comb begin
    cpu_count = '0;
    for (int i = 0; i < CPUS; i++) begin
      if (ctl.cpu_ok && ctl.cpu_id == 3'(i)) begin
        cpu_count = rec_out.counts[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/page_hotness_counter_table_core.sv =====
// Top level of the page hotness counter table: record memory, pipeline, result register.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall): cmd, page_index, cpu_id. One item per
//   command; every item yields exactly one result on the response channel
//   (rsp_valid / rsp_stall) carrying cpu_count and total_count after the command.
//   cold_threshold is written through cfg_wr_en / cfg_wr_data while the block is idle.
// Timing:
//   The record memory is read at the accepting edge; update, write-back and result
//   register load follow together when the update stage advances. Throughput is one
//   item per cycle while rsp_stall is low; back-to-back commands to the same page are
//   served by forwarding the last written record past the memory read.
// Reset:
//   rst (synchronous) clears control state and sets cold_threshold to 8. The record
//   memory is then swept to zero, one page per cycle, while cmd_stall is held high.
// Stall:
//   While rsp_stall holds a result, the update stage keeps its item and the command
//   channel stalls only once that stage is also occupied.
`default_nettype none

module page_hotness_counter_table_core
  import phct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  cmd,
  input  logic [9:0]  page_index,
  input  logic [2:0]  cpu_id,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  cpu_count,
  output logic [10:0] total_count
);

  state_t             state;
  logic [PAGE_AW-1:0] clr_addr;
  logic [7:0]         cold_threshold;

  rec_t               mem [PAGES];
  rec_t               rdata;

  logic               s1_valid;
  cmd_t               s1_cmd;
  logic [PAGE_AW-1:0] s1_addr;
  logic               s1_in_range;
  logic [2:0]         s1_cpu_id;

  logic               fwd_valid;
  logic [PAGE_AW-1:0] fwd_addr;
  rec_t               fwd_data;

  logic               accept;
  logic               s1_go;
  logic               mem_we;
  logic [PAGE_AW-1:0] mem_waddr;
  rec_t               mem_wdata;
  rec_t               rec_cur;
  rec_t               rec_new;
  logic [7:0]         upd_cpu_count;
  upd_ctl_t           upd_ctl;

  assign s1_go     = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = (state != ST_RUN) || (s1_valid && !s1_go);
  assign accept    = cmd_valid && !cmd_stall;

  // Newest copy of the page wins over the memory read.
  assign rec_cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;

  assign upd_ctl.op     = s1_cmd;
  assign upd_ctl.cpu_id = s1_cpu_id;
  assign upd_ctl.cpu_ok = 32'(s1_cpu_id) < CPUS;

  phct_update u_update (
    .ctl            (upd_ctl),
    .cold_threshold (cold_threshold),
    .rec_in         (rec_cur),
    .rec_out        (rec_new),
    .cpu_count      (upd_cpu_count)
  );

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_go && s1_in_range;
      mem_waddr = s1_addr;
      mem_wdata = rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rdata <= mem[PAGE_AW'(page_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + PAGE_AW'(1);
          if (clr_addr == PAGE_AW'(PAGES - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cold_threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      cold_threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= cmd_t'(cmd);
      s1_addr     <= PAGE_AW'(page_index);
      s1_in_range <= 32'(page_index) < PAGES;
      s1_cpu_id   <= cpu_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_go && s1_in_range) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_in_range) begin
      fwd_addr <= s1_addr;
      fwd_data <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      cpu_count   <= s1_in_range ? upd_cpu_count : 8'd0;
      total_count <= s1_in_range ? rec_new.total : 11'd0;
    end
  end

  a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> cmd_stall)
    else $error("command taken during memory clear");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (total_count <= TOTAL_BOUND))
    else $error("total count above sum of per-cpu limits");

  a_update_to_result: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> rsp_valid)
    else $error("updated item did not reach result register");

  a_update_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_addr) && $stable(s1_cmd)))
    else $error("held update stage lost its item");

endmodule

`default_nettype wire

// ===== bench/page_hotness_counter_table_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the page hotness counter table core.
module page_hotness_counter_table_core_tb;
  import phct_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int SAT_CPUS     = 2;
  localparam int RANDOM_ITEMS = 180;

  typedef struct {
    cmd_t        op;
    logic [9:0]  page;
    logic [2:0]  cpu;
    logic [7:0]  cpu_count;
    logic [10:0] total;
  } page_result_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        cmd_valid   = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd_op      = CMD_ACCESS;
  logic [9:0]  page_index  = '0;
  logic [2:0]  cpu_id      = '0;
  logic        rsp_valid;
  logic        rsp_stall   = 1'b0;
  logic [7:0]  cpu_count;
  logic [10:0] total_count;

  // Shadow copy of the page table and the threshold register.
  logic [7:0]  hits_model [PAGES][CPUS];
  logic [10:0] total_model [PAGES];
  logic [7:0]  age_model [PAGES];
  logic [7:0]  threshold_model;

  page_result_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count    = 0;
  int stall_run      = 0;
  bit no_gaps        = 1'b0;

  always #6 clk = ~clk;

  page_hotness_counter_table_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd_op),
    .page_index  (page_index),
    .cpu_id      (cpu_id),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .cpu_count   (cpu_count),
    .total_count (total_count)
  );

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
  endfunction

  // Updates the shadow table for one command and returns the expected item.
  function automatic page_result_t apply_page_command(cmd_t op, logic [9:0] page,
                                                      logic [2:0] cpu);
    page_result_t r;
    logic [7:0]   age;
    logic [10:0]  total;
    bit           cpu_ok;
    age    = age_model[page];
    total  = total_model[page];
    cpu_ok = int'(cpu) < CPUS;
    case (op)
      CMD_ACCESS: begin
        if (cpu_ok) begin
          if (hits_model[page][cpu] != COUNT_MAX) begin
            hits_model[page][cpu] = hits_model[page][cpu] + 8'd1;
            if (total != TOTAL_MAX) total = total + 11'd1;
          end
          age = '0;
        end
      end
      CMD_AGE_TICK: begin
        if (age != AGE_MAX) age = age + 8'd1;
        if (age > threshold_model) begin
          if (total != '0) total = total - 11'd1;
          // cold page: drop the whole record
          if (total == '0) begin
            age = '0;
            for (int c = 0; c < CPUS; c++) hits_model[page][c] = '0;
          end
        end
      end
      CMD_CLR_COUNT: begin
        total = '0;
        for (int c = 0; c < CPUS; c++) hits_model[page][c] = '0;
      end
      default: begin
        age = '0;
      end
    endcase
    total_model[page] = total;
    age_model[page]   = age;
    r.op        = op;
    r.page      = page;
    r.cpu       = cpu;
    r.cpu_count = cpu_ok ? hits_model[page][cpu] : 8'd0;
    r.total     = total;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    page_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item: cpu_count %0d total_count %0d",
                                  cpu_count, total_count));
      end else begin
        want = pending_results.pop_front();
        if (cpu_count !== want.cpu_count)
          report_mismatch($sformatf("cpu_count %s page %0d cpu %0d: want %0d got %0d",
                                    want.op.name(), want.page, want.cpu,
                                    want.cpu_count, cpu_count));
        if (total_count !== want.total)
          report_mismatch($sformatf("total_count %s page %0d cpu %0d: want %0d got %0d",
                                    want.op.name(), want.page, want.cpu,
                                    want.total, total_count));
      end
    end
  end

  // Receiver back-pressure: random runs, mostly short.
  always @(posedge clk) begin
    if (rst || no_gaps) begin
      rsp_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if ($urandom_range(0, 3) == 0) begin
      rsp_stall <= 1'b1;
      stall_run = pick_gap();
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_cmd(cmd_t op, logic [9:0] page, logic [2:0] cpu);
    int gap;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      // garbage on the payload while valid is low
      cmd_valid  <= 1'b0;
      cmd_op     <= cmd_t'($urandom_range(0, 3));
      page_index <= 10'($urandom_range(0, 1023));
      cpu_id     <= 3'($urandom_range(0, 7));
      repeat (gap) @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    cmd_op     <= op;
    page_index <= page;
    cpu_id     <= cpu;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_results.push_back(apply_page_command(op, page, cpu));
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    cmd_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (cmd_stall) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    threshold_model = value;
  endtask

  task automatic test_directed();
    // reset threshold of 8 first: a single tick stays warm
    send_cmd(CMD_ACCESS,    10'd0,    3'd0);
    send_cmd(CMD_ACCESS,    10'd1023, 3'd7);
    send_cmd(CMD_ACCESS,    10'd1023, 3'd7);
    send_cmd(CMD_ACCESS,    10'd1023, 3'd3);
    send_cmd(CMD_ACCESS,    10'h2AA,  3'd5);
    send_cmd(CMD_ACCESS,    10'h155,  3'd2);
    send_cmd(CMD_AGE_TICK,  10'd1023, 3'd7);
    send_cmd(CMD_CLR_AGE,   10'd1023, 3'd7);
    send_cmd(CMD_AGE_TICK,  10'h2AA,  3'd5);
    send_cmd(CMD_CLR_COUNT, 10'h155,  3'd2);
    send_cmd(CMD_ACCESS,    10'h155,  3'd2);
    write_threshold(8'd0);
    send_cmd(CMD_AGE_TICK,  10'd512,  3'd1);  // total already zero
    send_cmd(CMD_AGE_TICK,  10'd0,    3'd0);  // total drops to zero
    send_cmd(CMD_AGE_TICK,  10'd1023, 3'd3);
    send_cmd(CMD_AGE_TICK,  10'd1023, 3'd7);
    send_cmd(CMD_ACCESS,    10'd1023, 3'd6);
    cmd_valid <= 1'b0;
    wait_for_results();
    send_cmd(CMD_AGE_TICK,  10'd1023, 3'd6);
    send_cmd(CMD_AGE_TICK,  10'd1023, 3'd6);
    send_cmd(CMD_AGE_TICK,  10'd1023, 3'd6);
    send_cmd(CMD_CLR_AGE,   10'd0,    3'd4);
    send_cmd(CMD_CLR_COUNT, 10'd1023, 3'd7);
  endtask

  // Drives two CPU counts of one page past 255 so they saturate.
  task automatic test_count_saturation();
    logic [9:0] pg;
    pg = 10'($urandom_range(0, 1023));
    for (int c = 0; c < SAT_CPUS; c++) begin
      no_gaps = (c < SAT_CPUS / 2);
      repeat (COUNT_MAX + 1) send_cmd(CMD_ACCESS, pg, 3'(c));
    end
    no_gaps = 1'b0;
    repeat (3) send_cmd(CMD_ACCESS, pg, 3'($urandom_range(0, 7)));
    repeat (3) send_cmd(CMD_AGE_TICK, pg, 3'($urandom_range(0, 7)));
    send_cmd(CMD_ACCESS, pg, 3'd2);
    send_cmd(CMD_CLR_COUNT, pg, 3'd5);
  endtask

  task automatic test_random_traffic(logic [7:0] thr, int n_items, bit quiet);
    logic [9:0] hot [4];
    logic [9:0] pg;
    int         sent;
    int         kind;
    int         n;
    int         ticks;
    cmd_t       op;
    write_threshold(thr);
    no_gaps = quiet;
    foreach (hot[i]) hot[i] = 10'($urandom_range(0, 1023));
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      pg   = hot[$urandom_range(0, 3)];
      if (kind < 45) begin
        // warm a page, then tick it so that it may go cold
        n = $urandom_range(1, 12);
        repeat (n) send_cmd(CMD_ACCESS, pg, 3'($urandom_range(0, 7)));
        ticks = n + $urandom_range(0, 3) +
                ((thr <= 40) ? int'(thr) : (($urandom_range(0, 7) == 0) ? 260 : 20));
        repeat (ticks) send_cmd(CMD_AGE_TICK, pg, 3'($urandom_range(0, 7)));
        sent += n + ticks;
      end else if (kind < 60) begin
        // cooling cut short by another command
        ticks = $urandom_range(1, (thr <= 40) ? int'(thr) + 4 : 30);
        repeat (ticks) send_cmd(CMD_AGE_TICK, pg, 3'($urandom_range(0, 7)));
        case ($urandom_range(0, 2))
          0:       op = CMD_ACCESS;
          1:       op = CMD_CLR_AGE;
          default: op = CMD_CLR_COUNT;
        endcase
        send_cmd(op, pg, 3'($urandom_range(0, 7)));
        sent += ticks + 1;
      end else if (kind < 90) begin
        n = $urandom_range(0, 99);
        op = (n < 55) ? CMD_ACCESS : (n < 88) ? CMD_AGE_TICK :
             (n < 94) ? CMD_CLR_AGE : CMD_CLR_COUNT;
        send_cmd(op, pg, 3'($urandom_range(0, 7)));
        sent++;
      end else begin
        send_cmd(cmd_t'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                 3'($urandom_range(0, 7)));
        sent++;
      end
      if ($urandom_range(0, 99) == 0) begin
        cmd_valid <= 1'b0;
        wait_for_results();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int p = 0; p < PAGES; p++) begin
      for (int c = 0; c < CPUS; c++) hits_model[p][c] = '0;
      total_model[p] = '0;
      age_model[p]   = '0;
    end
    threshold_model = THRESHOLD_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_count_saturation();
    test_random_traffic(8'd255, RANDOM_ITEMS, 1'b0);
    test_random_traffic(THRESHOLD_RESET, RANDOM_ITEMS, 1'b0);
    test_random_traffic(8'($urandom_range(1, 20)), RANDOM_ITEMS, 1'b0);
    test_random_traffic(8'($urandom_range(2, 6)), RANDOM_ITEMS, 1'b1);
    test_random_traffic(8'd0, RANDOM_ITEMS, 1'b0);
    cmd_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
